// ----- rtl/binary_morphology_3x3_core_assert.svh -----
// Assertion macros shared by the binary morphology core checker.
// No dependencies; pulled in with `include by files that assert.
`ifndef BINARY_MORPHOLOGY_3X3_CORE_ASSERT_SVH
`define BINARY_MORPHOLOGY_3X3_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmorph: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define BM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmorph: assertion failed");

`endif

// ----- rtl/bmorph_pkg.sv -----
// Shared types, constants and codes of the binary 3x3 morphology core.
// No dependencies; used by every module of the block.
package bmorph_pkg;

  // Geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  // Pending count of a stage never exceeds MAX_WIDTH + 2
  localparam int PEND_W     = $clog2(MAX_WIDTH + 3);

  // Window and line memory organization (rows interleaved over banks)
  localparam int WIN_N   = 3;
  localparam int MASK_W  = WIN_N * WIN_N;
  localparam int NBANK   = 4;
  localparam int BANK_W  = $clog2(NBANK);

  // Field widths
  localparam int PIX_W      = 8;
  localparam int DIM_W      = 11;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Register reset values
  localparam int RST_WIDTH     = 640;
  localparam int RST_HEIGHT    = 480;
  localparam int RST_THRESHOLD = 127;
  localparam int RST_MASK      = 186;

  typedef enum logic [MODE_W-1:0] {
    MODE_ERODE,
    MODE_DILATE,
    MODE_OPEN,
    MODE_CLOSE
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE,
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_THRESHOLD,
    CFG_MASK
  } cfg_idx_e;

  // Request and response payloads
  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel;
  } req_t;

  typedef struct packed {
    logic out_pixel;
    logic frame_last;
  } rsp_t;

  // Effective configuration (sizes held as size minus one)
  typedef struct packed {
    mode_e             mode;
    logic [COL_W-1:0]  wm1;
    logic [ROW_W-1:0]  hm1;
    logic [PIX_W-1:0]  threshold;
    logic [MASK_W-1:0] mask;
  } cfg_t;

  // Token entering a window stage
  typedef struct packed {
    logic has_pix;
    logic pix;
  } tok_t;

  // Token leaving a window stage
  typedef struct packed {
    logic has_res;
    logic value;
    logic last;
  } res_t;

endpackage

// ----- rtl/bmorph_cfg.sv -----
// Configuration register file of the binary 3x3 morphology core.
// Depends on bmorph_pkg; sizes are clamped to the supported range on write.
module bmorph_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bmorph_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bmorph_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output bmorph_pkg::cfg_t                   cfg_o
);

  logic [bmorph_pkg::DIM_W-1:0] width_m1;
  logic [bmorph_pkg::DIM_W-1:0] height_m1;

  bmorph_pkg::cfg_t cfg_q;

  // Size of zero acts as one, above the limit acts as the limit
  function automatic logic [bmorph_pkg::DIM_W-1:0] dim_m1(
    input logic [bmorph_pkg::DIM_W-1:0] v,
    input logic [bmorph_pkg::DIM_W-1:0] vmax
  );
    logic [bmorph_pkg::DIM_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > vmax) begin
      r = vmax - bmorph_pkg::DIM_W'(1);
    end else begin
      r = v - bmorph_pkg::DIM_W'(1);
    end
    return r;
  endfunction

  assign width_m1  = dim_m1(cfg_data_i, bmorph_pkg::DIM_W'(bmorph_pkg::MAX_WIDTH));
  assign height_m1 = dim_m1(cfg_data_i, bmorph_pkg::DIM_W'(bmorph_pkg::MAX_HEIGHT));

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= bmorph_pkg::MODE_ERODE;
      cfg_q.wm1       <= bmorph_pkg::COL_W'(bmorph_pkg::RST_WIDTH - 1);
      cfg_q.hm1       <= bmorph_pkg::ROW_W'(bmorph_pkg::RST_HEIGHT - 1);
      cfg_q.threshold <= bmorph_pkg::PIX_W'(bmorph_pkg::RST_THRESHOLD);
      cfg_q.mask      <= bmorph_pkg::MASK_W'(bmorph_pkg::RST_MASK);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bmorph_pkg::CFG_MODE: begin
          cfg_q.mode <= bmorph_pkg::mode_e'(cfg_data_i[bmorph_pkg::MODE_W-1:0]);
        end
        bmorph_pkg::CFG_WIDTH: begin
          cfg_q.wm1 <= width_m1[bmorph_pkg::COL_W-1:0];
        end
        bmorph_pkg::CFG_HEIGHT: begin
          cfg_q.hm1 <= height_m1[bmorph_pkg::ROW_W-1:0];
        end
        bmorph_pkg::CFG_THRESHOLD: begin
          cfg_q.threshold <= cfg_data_i[bmorph_pkg::PIX_W-1:0];
        end
        bmorph_pkg::CFG_MASK: begin
          cfg_q.mask <= cfg_data_i[bmorph_pkg::MASK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/bmorph_stage.sv -----
// One 3x3 window stage: banked line memory, emit control and window logic.
// Depends on bmorph_pkg; instantiated twice by the core, the second one used only in open and close modes.
module bmorph_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bmorph_pkg::cfg_t  cfg_i,
  input  logic              dilate_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bmorph_pkg::tok_t  in_tok_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bmorph_pkg::res_t  out_res_o
);

  localparam int COL_W  = bmorph_pkg::COL_W;
  localparam int ROW_W  = bmorph_pkg::ROW_W;
  localparam int PEND_W = bmorph_pkg::PEND_W;
  localparam int BANK_W = bmorph_pkg::BANK_W;
  localparam int NBANK  = bmorph_pkg::NBANK;
  localparam int WIN_N  = bmorph_pkg::WIN_N;
  localparam int MASK_W = bmorph_pkg::MASK_W;

  // Line memory: one word per column, one bit per row bank
  logic [NBANK-1:0] line_mem_q [bmorph_pkg::MAX_WIDTH];
  logic [NBANK-1:0] rd0_q, rd1_q;

  // Write side (next pixel to enter) and centre side (next pixel to emit)
  logic [COL_W-1:0]  icol_q, ccol_q;
  logic [ROW_W-1:0]  irow_q, crow_q;
  logic [BANK_W-1:0] ibank_q, cbank_q;
  logic [PEND_W-1:0] pend_q;

  // Window register stage
  logic              b_valid_q, b_has_res_q;
  logic              b_top_q, b_bot_q, b_left_q, b_right_q, b_last_q;
  logic [BANK_W-1:0] b_bank_q;
  logic              fwd0_q, fwd1_q, fwd_pix_q;
  logic [BANK_W-1:0] fwd_bank_q;
  logic [WIN_N-1:0]  prev_q;

  logic              accept, wr_en, emit;
  logic              last_row, pen_row, last_col;
  logic [PEND_W-1:0] pend_new, need, w_ext;
  logic [COL_W-1:0]  raddr1;
  logic [NBANK-1:0]  col0, col1;
  logic [BANK_W-1:0] bank_up, bank_dn;
  logic [MASK_W-1:0] win, in_img, sel;
  logic              hit;

  assign in_ready_o = !b_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign wr_en      = accept && in_tok_i.has_pix;

  // Emit decision: the centre goes out once its lower-right neighbour has
  // entered, or every in-image neighbour has near the end of the frame
  always_comb begin
    w_ext    = PEND_W'(cfg_i.wm1) + PEND_W'(1);
    pend_new = pend_q + PEND_W'(wr_en);
    last_row = (crow_q == cfg_i.hm1);
    pen_row  = (ROW_W'(crow_q + ROW_W'(1)) == cfg_i.hm1);
    last_col = (ccol_q == cfg_i.wm1);
    if (last_row) begin
      need = PEND_W'(COL_W'(cfg_i.wm1 - ccol_q));
    end else if (pen_row && last_col) begin
      need = w_ext;
    end else begin
      need = w_ext + PEND_W'(1);
    end
    emit   = accept && (pend_new > need);
    raddr1 = COL_W'(ccol_q + COL_W'(1));
  end

  // Line memory: bit write into the entering row's bank, two column reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem_q[icol_q][ibank_q] <= in_tok_i.pix;
    end
    if (emit) begin
      rd0_q <= line_mem_q[ccol_q];
      rd1_q <= line_mem_q[raddr1];
    end
  end

  // Write and centre position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icol_q  <= '0;
      irow_q  <= '0;
      ibank_q <= '0;
      ccol_q  <= '0;
      crow_q  <= '0;
      cbank_q <= '0;
      pend_q  <= '0;
    end else begin
      if (wr_en) begin
        if (icol_q == cfg_i.wm1) begin
          icol_q  <= '0;
          irow_q  <= (irow_q == cfg_i.hm1) ? '0 : ROW_W'(irow_q + ROW_W'(1));
          ibank_q <= BANK_W'(ibank_q + BANK_W'(1));
        end else begin
          icol_q <= COL_W'(icol_q + COL_W'(1));
        end
      end
      if (emit) begin
        if (last_col) begin
          ccol_q  <= '0;
          crow_q  <= last_row ? '0 : ROW_W'(crow_q + ROW_W'(1));
          cbank_q <= BANK_W'(cbank_q + BANK_W'(1));
        end else begin
          ccol_q <= raddr1;
        end
      end
      pend_q <= pend_new - PEND_W'(emit);
    end
  end

  // Window stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      b_has_res_q <= 1'b0;
    end else if (accept) begin
      b_valid_q   <= 1'b1;
      b_has_res_q <= emit;
    end else if (out_ready_i) begin
      b_valid_q <= 1'b0;
    end
  end

  // Window stage payload, with forwarding of the pixel written this cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_top_q    <= (crow_q != '0);
      b_bot_q    <= !last_row;
      b_left_q   <= (ccol_q != '0);
      b_right_q  <= !last_col;
      b_last_q   <= last_row && last_col;
      b_bank_q   <= cbank_q;
      fwd0_q     <= wr_en && (icol_q == ccol_q);
      fwd1_q     <= wr_en && (icol_q == raddr1);
      fwd_bank_q <= ibank_q;
      fwd_pix_q  <= in_tok_i.pix;
    end
    // Centre column becomes the left column of the next centre
    if (b_valid_q && out_ready_i && b_has_res_q) begin
      prev_q <= {col0[bank_up], col0[b_bank_q], col0[bank_dn]};
    end
  end

  // Assemble the 3x3 neighbourhood and apply the structuring element
  always_comb begin
    logic [WIN_N-1:0] rok, cok;
    col0 = rd0_q;
    col1 = rd1_q;
    if (fwd0_q) begin
      col0[fwd_bank_q] = fwd_pix_q;
    end
    if (fwd1_q) begin
      col1[fwd_bank_q] = fwd_pix_q;
    end
    bank_up = BANK_W'(b_bank_q - BANK_W'(1));
    bank_dn = BANK_W'(b_bank_q + BANK_W'(1));
    win = {prev_q[2], col0[bank_up],  col1[bank_up],
           prev_q[1], col0[b_bank_q], col1[b_bank_q],
           prev_q[0], col0[bank_dn],  col1[bank_dn]};
    rok = {b_bot_q, 1'b1, b_top_q};
    cok = {b_right_q, 1'b1, b_left_q};
    for (int dr = 0; dr < WIN_N; dr++) begin
      for (int dc = 0; dc < WIN_N; dc++) begin
        in_img[MASK_W-1-(dr*WIN_N+dc)] = rok[dr] && cok[dc];
      end
    end
    sel = cfg_i.mask & in_img;
    hit = dilate_i ? |(sel & win) : |(sel & ~win);
  end

  assign out_valid_o       = b_valid_q;
  assign out_res_o.has_res = b_has_res_q;
  assign out_res_o.value   = dilate_i ? hit : !hit;
  assign out_res_o.last    = b_last_q;

endmodule

// ----- rtl/binary_morphology_3x3_core.sv -----
// Top level of the binary 3x3 morphology core (erode, dilate, open, close).
// Depends on bmorph_pkg, bmorph_cfg and bmorph_stage.
//
// Usage:
// - Request channel (req_valid_i / req_stall_o / req_i) takes grayscale
//   pixels in raster order (op = 0) or flush ticks (op = 1). A pixel at or
//   above the threshold is foreground.
// - Response channel (rsp_valid_o / rsp_stall_i / rsp_o) gives one result
//   pixel per image pixel in raster order; frame_last marks the last one.
// - Config channel (cfg_valid_i / cfg_ready_o) writes mode, width, height,
//   threshold and structuring mask by index; write only while idle.
// - A result trails its pixel by width+1 requests (one stage, erode or
//   dilate) or 2*(width+1) requests (two stages, open or close); after the
//   last pixel of a frame that many flush ticks or next-frame pixels drain it.
// - The completing request's result passes each stage's window register
//   and the output register to rsp_o. While req_stall_o is low, one request
//   per cycle is taken; each stage reads two line memory columns per result.
// - Reset clears counters and pipeline valids; line memories need no clear.
// - A stalled response holds in the output register; the stages keep taking
//   requests until their window registers are full, then req_stall_o rises.
module binary_morphology_3x3_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               req_valid_i,
  output logic                               req_stall_o,
  input  bmorph_pkg::req_t                   req_i,
  output logic                               rsp_valid_o,
  input  logic                               rsp_stall_i,
  output bmorph_pkg::rsp_t                   rsp_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bmorph_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bmorph_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  bmorph_pkg::cfg_t cfg;
  bmorph_pkg::tok_t s1_tok, s2_tok;
  bmorph_pkg::res_t s1_res, s2_res, src_res;

  logic two_stage, dilate1, dilate2;
  logic s1_in_ready, s1_out_valid, s1_out_ready;
  logic s2_in_valid, s2_in_ready, s2_out_valid, s2_out_ready;
  logic out_ready, src_valid, load;

  logic             rsp_valid_q;
  bmorph_pkg::rsp_t rsp_q;

  bmorph_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Mode decode
  assign two_stage = (cfg.mode == bmorph_pkg::MODE_OPEN) ||
                     (cfg.mode == bmorph_pkg::MODE_CLOSE);
  assign dilate1   = (cfg.mode == bmorph_pkg::MODE_DILATE) ||
                     (cfg.mode == bmorph_pkg::MODE_CLOSE);
  assign dilate2   = (cfg.mode == bmorph_pkg::MODE_OPEN);

  // Threshold into the first stage
  assign s1_tok.has_pix = !req_i.op;
  assign s1_tok.pix     = (req_i.pixel >= cfg.threshold);
  assign req_stall_o    = !s1_in_ready;

  // Output register can take a new result
  assign out_ready = !rsp_valid_q || !rsp_stall_i;

  assign s1_out_ready = two_stage ? s2_in_ready : (!s1_res.has_res || out_ready);

  bmorph_stage u_stage1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .dilate_i    (dilate1),
    .in_valid_i  (req_valid_i),
    .in_ready_o  (s1_in_ready),
    .in_tok_i    (s1_tok),
    .out_valid_o (s1_out_valid),
    .out_ready_i (s1_out_ready),
    .out_res_o   (s1_res)
  );

  // Every first-stage token steps the second stage in two-stage modes
  assign s2_in_valid    = two_stage && s1_out_valid;
  assign s2_tok.has_pix = s1_res.has_res;
  assign s2_tok.pix     = s1_res.value;
  assign s2_out_ready   = !s2_res.has_res || out_ready;

  bmorph_stage u_stage2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .dilate_i    (dilate2),
    .in_valid_i  (s2_in_valid),
    .in_ready_o  (s2_in_ready),
    .in_tok_i    (s2_tok),
    .out_valid_o (s2_out_valid),
    .out_ready_i (s2_out_ready),
    .out_res_o   (s2_res)
  );

  // Result source
  assign src_res   = two_stage ? s2_res : s1_res;
  assign src_valid = two_stage ? (s2_out_valid && s2_res.has_res)
                               : (s1_out_valid && s1_res.has_res);
  assign load      = src_valid && out_ready;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (load) begin
      rsp_valid_q <= 1'b1;
    end else if (!rsp_stall_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_q.out_pixel  <= src_res.value;
      rsp_q.frame_last <= src_res.last;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ----- rtl/bmorph_checker.sv -----
// Port-level checker for the binary 3x3 morphology core, bound to the top.
// Depends on bmorph_pkg and the assertion macro header.
`include "binary_morphology_3x3_core_assert.svh"

module bmorph_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_stall_i,
  input logic             rsp_valid_i,
  input logic             rsp_stall_i,
  input bmorph_pkg::rsp_t rsp_i
);

  // With room at the output, the pipeline never backs up to the input
  `BM_ASSERT_NOW(a_no_stall_when_out_free, clk_i, rst_ni, !rsp_valid_i || !rsp_stall_i, !req_stall_i)

  // No response right out of reset
  `BM_ASSERT_NOW(a_idle_after_reset, clk_i, rst_ni, !$past(rst_ni), !rsp_valid_i)

  // Stalled response stays offered and unchanged
  `BM_ASSERT_NEXT(a_rsp_valid_held, clk_i, rst_ni, rsp_valid_i && rsp_stall_i, rsp_valid_i)
  `BM_ASSERT_NEXT(a_rsp_data_held, clk_i, rst_ni, rsp_valid_i && rsp_stall_i, $stable(rsp_i))

endmodule

bind binary_morphology_3x3_core bmorph_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_stall_i (req_stall_o),
  .rsp_valid_i (rsp_valid_o),
  .rsp_stall_i (rsp_stall_i),
  .rsp_i       (rsp_o)
);
